### src/mpq_pkg.sv
// package: types, constants and defaults for the priority ready queue
package mpq_pkg;

  localparam int unsigned NumSlotsDef  = 64;
  localparam int unsigned NumLevelsDef = 10;
  localparam int unsigned ResetPrio    = 5;
  localparam int unsigned SlotW        = 6;
  localparam int unsigned PrioW        = 4;
  localparam int unsigned FifoDepth    = 2;

  typedef enum logic [2:0] {
    CMD_ENQUEUE = 3'd0,
    CMD_PICK    = 3'd1,
    CMD_REMOVE  = 3'd2,
    CMD_SETPRIO = 3'd3,
    CMD_GETPRIO = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BADPRIO = 2'd2,
    ST_BADSLOT = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [SlotW-1:0] slot;
    logic [PrioW-1:0] new_priority;
  } req_t;

  typedef struct packed {
    logic [SlotW-1:0] out_slot;
    logic [PrioW-1:0] out_priority;
    logic [1:0]       status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDHEAD,
    S_WALK,
    S_WALKCHK,
    S_PUSH,
    S_OUT
  } state_e;

endpackage

### src/multilevel_priority_ready_queue_top.sv
// top level of the multilevel priority ready queue
// Ready queue for NUM_SLOTS task slots over NUM_LEVELS priority levels (0 most urgent),
// each level a linked list held in a link ram. Commands pass through a two-entry request
// queue into a list engine that runs one command at a time. Remove and requeue walk the
// level list one link ram read per cycle.
module multilevel_priority_ready_queue_top #(
  parameter int unsigned NUM_SLOTS  = mpq_pkg::NumSlotsDef,
  parameter int unsigned NUM_LEVELS = mpq_pkg::NumLevelsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mpq_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mpq_pkg::rsp_t out_data_o
);

  logic          q_valid, q_ready;
  mpq_pkg::req_t q_data;

  mpq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .data_o  (q_data)
  );

  mpq_engine #(.NumSlots(NUM_SLOTS), .NumLevels(NUM_LEVELS)) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .ready_o (q_ready),
    .req_i   (q_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .rsp_o   (out_data_o)
  );

endmodule

### src/mpq_ram.sv
// generic single write port ram with registered read
module mpq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/mpq_fifo.sv
// short request queue between command intake and the list engine
module mpq_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  mpq_pkg::req_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output mpq_pkg::req_t data_o
);

  localparam int unsigned D = mpq_pkg::FifoDepth;

  mpq_pkg::req_t    buf_q [D];
  logic [$clog2(D)-1:0] wp_q, rp_q;
  logic [$clog2(D):0]   cnt_q;
  logic push, pop;

  assign ready_o = (cnt_q != ($clog2(D)+1)'(D));
  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rp_q];
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + ($clog2(D)+1)'(push) - ($clog2(D)+1)'(pop);
    end
  end

endmodule

### src/mpq_engine.sv
// list engine: carries out one command at a time on the level lists
module mpq_engine #(
  parameter int unsigned NumSlots  = mpq_pkg::NumSlotsDef,
  parameter int unsigned NumLevels = mpq_pkg::NumLevelsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  mpq_pkg::req_t req_i,
  output logic          valid_o,
  input  logic          ready_i,
  output mpq_pkg::rsp_t rsp_o
);

  localparam int unsigned SW = mpq_pkg::SlotW;
  localparam int unsigned PW = mpq_pkg::PrioW;
  localparam int unsigned AW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int unsigned LW = $clog2(NumLevels);
  localparam int unsigned DefPrio = (mpq_pkg::ResetPrio < NumLevels) ?
                                    mpq_pkg::ResetPrio : NumLevels - 1;

  mpq_pkg::state_e state_q, state_d;
  mpq_pkg::req_t   req_q;
  mpq_pkg::rsp_t   rsp_q, rsp_d;

  logic [NumSlots-1:0]  queued_q, queued_d;
  logic [NumSlots-1:0]  pset_q, pset_d;
  logic [PW-1:0]        sprio_q, sprio_d;
  logic [SW-1:0]        head_q [NumLevels];
  logic [SW-1:0]        tail_q [NumLevels];
  logic [NumLevels-1:0] ne_q, ne_d;
  logic [SW-1:0]        prev_q, prev_d;
  logic [AW:0]          cnt_q, cnt_d;
  logic                 moving_q, moving_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [SW-1:0] wdata, rdata;

  mpq_ram #(.Width(SW), .Depth(NumSlots)) u_link (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic          slot_ok;
  logic [AW-1:0] sidx;
  logic [PW-1:0] sprio;
  logic [LW-1:0] slvl;
  logic          pick_found;
  logic [LW-1:0] pick_lvl;
  logic [AW-1:0] hidx;

  logic          hd_we, tl_we, pr_we;
  logic [LW-1:0] hd_l, tl_l;
  logic [SW-1:0] hd_v, tl_v;
  logic [PW-1:0] pr_v;

  logic [AW-1:0] praddr;
  logic [PW-1:0] prdata;

  // stored priorities; slot read at intake, head read for pick
  mpq_ram #(.Width(PW), .Depth(NumSlots)) u_prio (
    .clk_i   (clk_i),
    .we_i    (pr_we),
    .waddr_i (sidx),
    .wdata_i (pr_v),
    .raddr_i (praddr),
    .rdata_o (prdata)
  );

  assign praddr  = (state_q == mpq_pkg::S_IDLE) ? AW'(req_i.slot) : hidx;

  assign slot_ok = ({{(32-SW){1'b0}}, req_q.slot} < NumSlots);
  assign sidx    = AW'(req_q.slot);
  assign sprio   = (state_q == mpq_pkg::S_RDHEAD) ?
                   (pset_q[sidx] ? prdata : PW'(DefPrio)) : sprio_q;
  assign slvl    = (32'(sprio) < NumLevels) ? LW'(sprio) : LW'(NumLevels - 1);

  always_comb begin
    pick_found = 1'b0;
    pick_lvl   = '0;
    for (int l = NumLevels - 1; l >= 0; l--) begin
      if (ne_q[l]) begin
        pick_found = 1'b1;
        pick_lvl   = LW'(l);
      end
    end
  end

  assign hidx = AW'(head_q[pick_lvl]);

  assign ready_o = (state_q == mpq_pkg::S_IDLE);
  assign valid_o = (state_q == mpq_pkg::S_OUT);
  assign rsp_o   = rsp_q;

  // next state and datapath updates
  always_comb begin
    state_d  = state_q;
    rsp_d    = rsp_q;
    queued_d = queued_q;
    pset_d   = pset_q;
    ne_d     = ne_q;
    prev_d   = prev_q;
    cnt_d    = cnt_q;
    moving_d = moving_q;
    sprio_d  = sprio;
    we = 1'b0; waddr = sidx; wdata = req_q.slot; raddr = sidx;
    hd_we = 1'b0; hd_l = slvl; hd_v = req_q.slot;
    tl_we = 1'b0; tl_l = slvl; tl_v = req_q.slot;
    pr_we = 1'b0; pr_v = req_q.new_priority;
    case (state_q)
      mpq_pkg::S_IDLE: begin
        if (valid_i) state_d = mpq_pkg::S_RDHEAD;
      end
      mpq_pkg::S_RDHEAD: begin
        rsp_d = '{out_slot: req_q.slot, out_priority: '0, status: mpq_pkg::ST_OK};
        moving_d = 1'b0;
        state_d  = mpq_pkg::S_OUT;
        raddr    = sidx;
        if (req_q.cmd == mpq_pkg::CMD_PICK) begin
          if (!pick_found) begin
            rsp_d.status = mpq_pkg::ST_EMPTY;
          end else begin
            raddr = hidx;
            state_d = mpq_pkg::S_WALK;
          end
        end else if (req_q.cmd inside {mpq_pkg::CMD_ENQUEUE, mpq_pkg::CMD_REMOVE,
                                       mpq_pkg::CMD_SETPRIO, mpq_pkg::CMD_GETPRIO}) begin
          if (!slot_ok) begin
            rsp_d.status = mpq_pkg::ST_BADSLOT;
          end else begin
            rsp_d.out_priority = sprio;
            case (req_q.cmd)
              mpq_pkg::CMD_ENQUEUE: begin
                if (queued_q[sidx]) rsp_d.status = mpq_pkg::ST_BADSLOT;
                else state_d = mpq_pkg::S_PUSH;
              end
              mpq_pkg::CMD_REMOVE: begin
                if (!queued_q[sidx]) rsp_d.status = mpq_pkg::ST_BADSLOT;
                else state_d = mpq_pkg::S_WALK;
              end
              mpq_pkg::CMD_SETPRIO: begin
                if (32'(req_q.new_priority) >= NumLevels) begin
                  rsp_d.status = mpq_pkg::ST_BADPRIO;
                end else begin
                  rsp_d.out_priority = req_q.new_priority;
                  if (queued_q[sidx]) begin
                    moving_d = 1'b1;
                    state_d  = mpq_pkg::S_WALK;
                  end else begin
                    pr_we = 1'b1;
                    pset_d[sidx] = 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end
      mpq_pkg::S_WALK: begin
        // link of the head (pick) or of the slot itself (unlink) is in rdata
        if (req_q.cmd == mpq_pkg::CMD_PICK) begin
          queued_d[hidx] = 1'b0;
          rsp_d.out_slot = head_q[pick_lvl];
          rsp_d.out_priority = pset_q[hidx] ? prdata : PW'(DefPrio);
          if (tail_q[pick_lvl] == head_q[pick_lvl]) begin
            ne_d[pick_lvl] = 1'b0;
          end else begin
            hd_we = 1'b1; hd_l = pick_lvl; hd_v = rdata;
          end
          state_d = mpq_pkg::S_OUT;
        end else begin
          queued_d[sidx] = 1'b0;
          if (!ne_q[slvl]) begin
            state_d = moving_q ? mpq_pkg::S_PUSH : mpq_pkg::S_OUT;
          end else if (head_q[slvl] == req_q.slot) begin
            if (tail_q[slvl] == req_q.slot) ne_d[slvl] = 1'b0;
            else begin
              hd_we = 1'b1; hd_v = rdata;
            end
            state_d = moving_q ? mpq_pkg::S_PUSH : mpq_pkg::S_OUT;
          end else begin
            // remember the slot's own link, then walk from the head
            wdata    = rdata;
            prev_d   = head_q[slvl];
            cnt_d    = '0;
            raddr    = AW'(head_q[slvl]);
            rsp_d.out_slot = rdata;
            state_d  = mpq_pkg::S_WALKCHK;
          end
        end
      end
      mpq_pkg::S_WALKCHK: begin
        // rdata holds next_link[prev]; the slot's link is parked in rsp out_slot
        raddr = AW'(rdata);
        if (32'(prev_q) >= NumSlots || prev_q == tail_q[slvl] ||
            32'(cnt_q) >= NumSlots) begin
          rsp_d.out_slot = req_q.slot;
          state_d = moving_q ? mpq_pkg::S_PUSH : mpq_pkg::S_OUT;
        end else if (rdata == req_q.slot) begin
          we = 1'b1; waddr = AW'(prev_q); wdata = rsp_q.out_slot;
          if (tail_q[slvl] == req_q.slot) begin
            tl_we = 1'b1; tl_v = prev_q;
          end
          rsp_d.out_slot = req_q.slot;
          state_d = moving_q ? mpq_pkg::S_PUSH : mpq_pkg::S_OUT;
        end else begin
          prev_d = rdata;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      mpq_pkg::S_PUSH: begin
        if (moving_q) begin
          pr_we = 1'b1;
          pset_d[sidx] = 1'b1;
          sprio_d  = req_q.new_priority;
          moving_d = 1'b0;
          state_d  = mpq_pkg::S_PUSH;
        end else begin
          queued_d[sidx] = 1'b1;
          if (ne_q[slvl]) begin
            we = 1'b1; waddr = AW'(tail_q[slvl]);
            tl_we = 1'b1;
          end else begin
            hd_we = 1'b1; tl_we = 1'b1;
            ne_d[slvl] = 1'b1;
          end
          state_d = mpq_pkg::S_OUT;
        end
      end
      mpq_pkg::S_OUT: begin
        if (ready_i) state_d = mpq_pkg::S_IDLE;
      end
      default: state_d = mpq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (hd_we) head_q[hd_l] <= hd_v;
    if (tl_we) tail_q[tl_l] <= tl_v;
    if (valid_i && ready_o) req_q <= req_i;
    rsp_q   <= rsp_d;
    prev_q  <= prev_d;
    cnt_q   <= cnt_d;
    sprio_q <= sprio_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mpq_pkg::S_IDLE;
      queued_q <= '0;
      pset_q   <= '0;
      ne_q     <= '0;
      moving_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      queued_q <= queued_d;
      pset_q   <= pset_d;
      ne_q     <= ne_d;
      moving_q <= moving_d;
    end
  end

endmodule

### bench/multilevel_priority_ready_queue_top_tb.sv
// testbench: directed table and random command mix checked against a ready queue predictor
module multilevel_priority_ready_queue_top_tb;

  localparam int NSLOT = 64;
  localparam int NLVL = 10;
  localparam int NRAND = 930;
  localparam int WDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  mpq_pkg::req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  mpq_pkg::rsp_t out_data_o;

  always #2 clk_i = ~clk_i;

  multilevel_priority_ready_queue_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  // predictor state: each level kept as a plain queue of slots
  int unsigned lvl_q[NLVL][$];
  bit slot_in_q[NSLOT];
  logic [3:0] slot_prio[NSLOT];
  mpq_pkg::rsp_t pending_rsp[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit stim_done = 1'b0;
  int wdog = 0;

  function automatic void drop_from_level(int unsigned s);
    int unsigned l;
    l = 32'(slot_prio[s]);
    for (int i = 0; i < lvl_q[l].size(); i++) begin
      if (lvl_q[l][i] == s) begin
        lvl_q[l].delete(i);
        break;
      end
    end
    slot_in_q[s] = 1'b0;
  endfunction

  function automatic mpq_pkg::rsp_t schedule_cmd(mpq_pkg::req_t r);
    mpq_pkg::rsp_t o;
    int unsigned s;
    o.out_slot = r.slot;
    o.out_priority = '0;
    o.status = mpq_pkg::ST_OK;
    s = 32'(r.slot);
    case (r.cmd)
      mpq_pkg::CMD_PICK: begin
        o.status = mpq_pkg::ST_EMPTY;
        for (int l = 0; l < NLVL; l++) begin
          if (lvl_q[l].size() != 0) begin
            s = lvl_q[l].pop_front();
            slot_in_q[s] = 1'b0;
            o.out_slot = 6'(s);
            o.out_priority = slot_prio[s];
            o.status = mpq_pkg::ST_OK;
            break;
          end
        end
      end
      mpq_pkg::CMD_ENQUEUE: begin
        if (slot_in_q[s]) o.status = mpq_pkg::ST_BADSLOT;
        else begin
          lvl_q[slot_prio[s]].push_back(s);
          slot_in_q[s] = 1'b1;
        end
        o.out_priority = slot_prio[s];
      end
      mpq_pkg::CMD_REMOVE: begin
        if (!slot_in_q[s]) o.status = mpq_pkg::ST_BADSLOT;
        else drop_from_level(s);
        o.out_priority = slot_prio[s];
      end
      mpq_pkg::CMD_SETPRIO: begin
        if (r.new_priority >= NLVL) o.status = mpq_pkg::ST_BADPRIO;
        else if (slot_in_q[s]) begin
          drop_from_level(s);
          slot_prio[s] = r.new_priority;
          lvl_q[slot_prio[s]].push_back(s);
          slot_in_q[s] = 1'b1;
        end else slot_prio[s] = r.new_priority;
        o.out_priority = slot_prio[s];
      end
      mpq_pkg::CMD_GETPRIO: o.out_priority = slot_prio[s];
      default: ;
    endcase
    return o;
  endfunction

  task automatic send_cmd(mpq_pkg::req_t r);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_rsp.push_back(schedule_cmd(r));
  endtask

  task automatic send_fixed(logic [2:0] c, int unsigned s, int unsigned p);
    mpq_pkg::req_t r;
    r.cmd = c;
    r.slot = 6'(s);
    r.new_priority = 4'(p);
    send_cmd(r);
  endtask

  function automatic mpq_pkg::req_t rand_cmd();
    mpq_pkg::req_t r;
    int unsigned k;
    k = $urandom_range(0, 99);
    r.slot = 6'((k < 80) ? $urandom_range(0, 11) : $urandom_range(0, NSLOT - 1));
    r.new_priority = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(10, 15)
                                                    : $urandom_range(0, 9));
    k = $urandom_range(0, 99);
    if (k < 35) r.cmd = mpq_pkg::CMD_ENQUEUE;
    else if (k < 55) r.cmd = mpq_pkg::CMD_PICK;
    else if (k < 70) r.cmd = mpq_pkg::CMD_REMOVE;
    else if (k < 85) r.cmd = mpq_pkg::CMD_SETPRIO;
    else if (k < 96) r.cmd = mpq_pkg::CMD_GETPRIO;
    else r.cmd = 3'($urandom_range(5, 7));
    return r;
  endfunction

  // directed table; expected result given where obvious, else predictor only
  typedef struct {
    logic [2:0] cmd;
    int unsigned slot;
    int unsigned prio;
    bit has_exp;
    mpq_pkg::rsp_t exp;
  } row_t;
  row_t rows[$];

  function automatic mpq_pkg::rsp_t mk(int unsigned s, int unsigned p, mpq_pkg::status_e st);
    mpq_pkg::rsp_t o;
    o.out_slot = 6'(s);
    o.out_priority = 4'(p);
    o.status = st;
    return o;
  endfunction

  initial begin
    rows.push_back('{mpq_pkg::CMD_PICK, 63, 15, 1, mk(63, 0, mpq_pkg::ST_EMPTY)});
    rows.push_back('{mpq_pkg::CMD_GETPRIO, 0, 0, 1, mk(0, 5, mpq_pkg::ST_OK)});
    rows.push_back('{mpq_pkg::CMD_REMOVE, 7, 0, 1, mk(7, 5, mpq_pkg::ST_BADSLOT)});
    rows.push_back('{mpq_pkg::CMD_SETPRIO, 3, 15, 1, mk(3, 5, mpq_pkg::ST_BADPRIO)});
    rows.push_back('{mpq_pkg::CMD_SETPRIO, 3, 10, 1, mk(3, 5, mpq_pkg::ST_BADPRIO)});
    rows.push_back('{mpq_pkg::CMD_ENQUEUE, 63, 0, 1, mk(63, 5, mpq_pkg::ST_OK)});
    rows.push_back('{mpq_pkg::CMD_ENQUEUE, 63, 0, 1, mk(63, 5, mpq_pkg::ST_BADSLOT)});
    rows.push_back('{3'd5, 42, 9, 1, mk(42, 0, mpq_pkg::ST_OK)});
    rows.push_back('{3'd7, 21, 6, 1, mk(21, 0, mpq_pkg::ST_OK)});
    rows.push_back('{mpq_pkg::CMD_SETPRIO, 0, 0, 0, '0});
    rows.push_back('{mpq_pkg::CMD_SETPRIO, 1, 9, 0, '0});
    rows.push_back('{mpq_pkg::CMD_ENQUEUE, 1, 0, 0, '0});
    rows.push_back('{mpq_pkg::CMD_ENQUEUE, 0, 0, 0, '0});
    rows.push_back('{mpq_pkg::CMD_ENQUEUE, 2, 0, 0, '0});
    rows.push_back('{mpq_pkg::CMD_SETPRIO, 63, 5, 0, '0});
    rows.push_back('{mpq_pkg::CMD_ENQUEUE, 4, 0, 0, '0});
    rows.push_back('{mpq_pkg::CMD_REMOVE, 63, 0, 0, '0});
    rows.push_back('{mpq_pkg::CMD_SETPRIO, 2, 5, 0, '0});
    rows.push_back('{mpq_pkg::CMD_PICK, 0, 0, 0, '0});
    rows.push_back('{mpq_pkg::CMD_PICK, 0, 0, 0, '0});
    rows.push_back('{mpq_pkg::CMD_PICK, 0, 0, 0, '0});
    rows.push_back('{mpq_pkg::CMD_PICK, 0, 0, 0, '0});
    rows.push_back('{mpq_pkg::CMD_PICK, 0, 0, 0, '0});
    rows.push_back('{mpq_pkg::CMD_GETPRIO, 42, 0, 0, '0});

    for (int i = 0; i < NSLOT; i++) slot_prio[i] = 4'd5;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        mpq_pkg::rsp_t p;
        send_fixed(rows[i].cmd, rows[i].slot, rows[i].prio);
        p = pending_rsp[$];
        if (p !== rows[i].exp) begin
          $display("%0t table row %0d: expected %h actual %h", $time, i, rows[i].exp, p);
          errors++;
        end
      end else send_fixed(rows[i].cmd, rows[i].slot, rows[i].prio);
    end

    for (int n = 0; n < NRAND; n++) begin
      if (n == NRAND - 100) quiet = 1'b1;
      send_cmd(rand_cmd());
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // receive side: random stalls, compare with oldest expectation
  initial begin
    int unsigned stall;
    forever begin
      @(posedge clk_i);
      if (!quiet && out_ready_i && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 3);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(posedge clk_i);
      end else out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t unexpected transfer: expected none actual %h", $time, out_data_o);
        errors++;
      end else begin
        mpq_pkg::rsp_t e;
        e = pending_rsp.pop_front();
        if (e.out_slot !== out_data_o.out_slot) begin
          $display("%0t out_slot: expected %0d actual %0d", $time, e.out_slot,
                   out_data_o.out_slot);
          errors++;
        end
        if (e.out_priority !== out_data_o.out_priority) begin
          $display("%0t out_priority: expected %0d actual %0d", $time, e.out_priority,
                   out_data_o.out_priority);
          errors++;
        end
        if (e.status !== out_data_o.status) begin
          $display("%0t status: expected %0d actual %0d", $time, e.status,
                   out_data_o.status);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("[multilevel_priority_ready_queue_top] ERROR");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (errors == 0) begin
      $display("[multilevel_priority_ready_queue_top] OK");
    end else begin
      $display("[multilevel_priority_ready_queue_top] ERROR");
    end
    $finish;
  end

endmodule
